FILE: src/stw_pkg.sv
// ----------------------------------------------------------------------------
// stw_pkg
// shared types, constants and helpers of the slotted timer wheel
// ----------------------------------------------------------------------------
package stw_pkg;

  localparam int SLOT_COUNT  = 128;
  localparam int SLOT_SHIFT  = 3;
  localparam int TIMER_COUNT = 64;

  localparam int SLOT_W = $clog2(SLOT_COUNT);
  localparam int TIX_W  = $clog2(TIMER_COUNT);
  localparam int CNT_W  = SLOT_W + 1;
  localparam int ID_W   = 6;
  localparam int LINK_W = 7;

  localparam logic [LINK_W-1:0] NIL_LINK  = 7'h7F;
  localparam logic [31:0]       SLOT_STEP = 32'(1 << SLOT_SHIFT);
  localparam logic [31:0]       SLOT_MASK = 32'((1 << SLOT_SHIFT) - 1);

  typedef enum logic [1:0] {
    FUNC_ARM    = 2'd0,
    FUNC_CANCEL = 2'd1,
    FUNC_TICK   = 2'd2,
    FUNC_NOP    = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    KIND_ARMED    = 3'd0,
    KIND_REJ_PEND = 3'd1,
    KIND_REJ_PAST = 3'd2,
    KIND_CANCEL   = 3'd3,
    KIND_EXPIRED  = 3'd4,
    KIND_NONE     = 3'd5
  } kind_e;

  typedef struct packed {
    logic [1:0]  func;
    logic [5:0]  timer_id;
    logic [31:0] expires;
    logic [31:0] now;
  } in_item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [5:0] timer_id_res;
    logic       was_active;
    logic       last;
  } out_item_t;

  function automatic logic [SLOT_W-1:0] slot_of(input logic [31:0] t);
    return t[SLOT_SHIFT +: SLOT_W];
  endfunction

endpackage

FILE: src/stw_ram.sv
// ----------------------------------------------------------------------------
// stw_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module stw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

FILE: src/stw_front.sv
// ----------------------------------------------------------------------------
// stw_front
// accepts commands, drops unused codes, queues the rest for the back end
// ----------------------------------------------------------------------------
module stw_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  stw_pkg::in_item_t in_item_i,
  output logic              q_valid_o,
  input  logic              q_pop_i,
  output stw_pkg::in_item_t q_item_o
);
  import stw_pkg::*;

  in_item_t   fifo_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       accept, push, pop;

  assign in_stall_o = (count_q == 2'd2);
  assign accept     = in_valid_i && !in_stall_o;
  // the unused code is a no-op with no result
  assign push       = accept && (in_item_i.func != FUNC_NOP);
  assign pop        = q_pop_i && (count_q != 2'd0);

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= in_item_i;
    end
  end

  assign q_valid_o = (count_q != 2'd0);
  assign q_item_o  = fifo_q[rd_ptr_q];
endmodule

FILE: src/stw_back.sv
// ----------------------------------------------------------------------------
// stw_back
// sequencer: sorted insert, unlink and slot walk over the link memories
// ----------------------------------------------------------------------------
module stw_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  output logic               q_pop_o,
  input  stw_pkg::in_item_t  q_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output stw_pkg::out_item_t out_item_o
);
  import stw_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_A_HEAD = 4'd1;
  localparam logic [3:0] S_A_CMP  = 4'd2;
  localparam logic [3:0] S_LINK1  = 4'd3;
  localparam logic [3:0] S_LINK2  = 4'd4;
  localparam logic [3:0] S_UNLINK = 4'd5;
  localparam logic [3:0] S_EMIT   = 4'd6;
  localparam logic [3:0] S_T_SLOT = 4'd7;
  localparam logic [3:0] S_T_HEAD = 4'd8;
  localparam logic [3:0] S_T_EXP  = 4'd9;
  localparam logic [3:0] S_T_END  = 4'd10;

  localparam logic [LINK_W-1:0] TC_L = LINK_W'(TIMER_COUNT);

  logic [3:0]        state_q, state_d;
  in_item_t          cmd_q, cmd_d;
  logic [LINK_W-1:0] cur_q, cur_d, prev_q, prev_d, guard_q, guard_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [31:0]       t_q, t_d, start_q, start_d, last_start_q, last_start_d;
  logic [CNT_W-1:0]  remain_q, remain_d;
  logic              hold_valid_q, hold_valid_d;
  logic [ID_W-1:0]   hold_id_q, hold_id_d;
  out_item_t         res_q, res_d;
  logic [TIMER_COUNT-1:0] pend_q, pend_d;
  logic [SLOT_COUNT-1:0]  hv_q, hv_d;
  out_item_t         out_q, out_d;
  logic              out_valid_q, out_load, out_free;

  // memory ports
  logic              exp_we, exp_re, nxt_we, nxt_re, prv_we, prv_re, head_we, head_re;
  logic [TIX_W-1:0]  exp_wa, exp_ra, nxt_wa, nxt_ra, prv_wa, prv_ra;
  logic [SLOT_W-1:0] head_wa, head_ra;
  logic [31:0]       exp_wd, exp_rd;
  logic [LINK_W-1:0] nxt_wd, nxt_rd, prv_wd, prv_rd, head_wd, head_rdata, head_rd;

  // combinational helpers
  logic              id_big;
  logic [TIX_W-1:0]  qid;
  logic [31:0]       q_start, diff, quot;
  logic [CNT_W-1:0]  count;
  logic [LINK_W-1:0] g_next;

  stw_ram #(.WIDTH(32), .DEPTH(TIMER_COUNT)) u_exp_ram (
    .clk_i, .we_i(exp_we), .waddr_i(exp_wa), .wdata_i(exp_wd),
    .re_i(exp_re), .raddr_i(exp_ra), .rdata_o(exp_rd)
  );
  stw_ram #(.WIDTH(LINK_W), .DEPTH(TIMER_COUNT)) u_nxt_ram (
    .clk_i, .we_i(nxt_we), .waddr_i(nxt_wa), .wdata_i(nxt_wd),
    .re_i(nxt_re), .raddr_i(nxt_ra), .rdata_o(nxt_rd)
  );
  stw_ram #(.WIDTH(LINK_W), .DEPTH(TIMER_COUNT)) u_prv_ram (
    .clk_i, .we_i(prv_we), .waddr_i(prv_wa), .wdata_i(prv_wd),
    .re_i(prv_re), .raddr_i(prv_ra), .rdata_o(prv_rd)
  );
  stw_ram #(.WIDTH(LINK_W), .DEPTH(SLOT_COUNT)) u_head_ram (
    .clk_i, .we_i(head_we), .waddr_i(head_wa), .wdata_i(head_wd),
    .re_i(head_re), .raddr_i(head_ra), .rdata_o(head_rdata)
  );

  assign head_rd  = hv_q[slot_q] ? head_rdata : NIL_LINK;
  assign out_free = !out_valid_q || !out_stall_i;
  assign id_big   = ({1'b0, q_item_i.timer_id} >= TC_L);
  assign qid      = q_item_i.timer_id[TIX_W-1:0];
  assign q_start  = q_item_i.now & ~SLOT_MASK;
  assign diff     = q_start - last_start_q;
  assign quot     = diff >> SLOT_SHIFT;
  assign g_next   = guard_q + LINK_W'(1);

  always_comb begin
    if (q_start < last_start_q) begin
      count = '0;
    end else if (quot >= 32'(SLOT_COUNT - 1)) begin
      count = CNT_W'(SLOT_COUNT);
    end else begin
      count = quot[CNT_W-1:0] + CNT_W'(1);
    end
  end

  always_comb begin
    state_d = state_q;  cmd_d = cmd_q;  cur_d = cur_q;  prev_d = prev_q;
    guard_d = guard_q;  slot_d = slot_q;  t_d = t_q;  start_d = start_q;
    last_start_d = last_start_q;  remain_d = remain_q;
    hold_valid_d = hold_valid_q;  hold_id_d = hold_id_q;  res_d = res_q;
    pend_d = pend_q;  hv_d = hv_q;
    out_load = 1'b0;  out_d = out_q;  q_pop_o = 1'b0;
    exp_we = 1'b0; exp_wa = '0; exp_wd = cmd_q.expires; exp_re = 1'b0; exp_ra = '0;
    nxt_we = 1'b0; nxt_wa = '0; nxt_wd = NIL_LINK; nxt_re = 1'b0; nxt_ra = '0;
    prv_we = 1'b0; prv_wa = '0; prv_wd = NIL_LINK; prv_re = 1'b0; prv_ra = '0;
    head_we = 1'b0; head_wa = slot_q; head_wd = NIL_LINK; head_re = 1'b0; head_ra = '0;

    case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          cmd_d   = q_item_i;
          case (q_item_i.func)
            FUNC_ARM: begin
              if (id_big || pend_q[qid]) begin
                res_d   = '{KIND_REJ_PEND, q_item_i.timer_id, 1'b0, 1'b1};
                state_d = S_EMIT;
              end else if (q_item_i.expires <= q_item_i.now) begin
                res_d   = '{KIND_REJ_PAST, q_item_i.timer_id, 1'b0, 1'b1};
                state_d = S_EMIT;
              end else begin
                head_re = 1'b1;
                head_ra = slot_of(q_item_i.expires);
                slot_d  = slot_of(q_item_i.expires);
                prev_d  = NIL_LINK;
                guard_d = '0;
                state_d = S_A_HEAD;
              end
            end
            FUNC_CANCEL: begin
              if (!id_big && pend_q[qid]) begin
                exp_re = 1'b1; exp_ra = qid;
                nxt_re = 1'b1; nxt_ra = qid;
                prv_re = 1'b1; prv_ra = qid;
                state_d = S_UNLINK;
              end else begin
                res_d   = '{KIND_CANCEL, q_item_i.timer_id, 1'b0, 1'b1};
                state_d = S_EMIT;
              end
            end
            FUNC_TICK: begin
              start_d      = q_start;
              t_d          = q_start;
              remain_d     = count;
              hold_valid_d = 1'b0;
              state_d      = S_T_SLOT;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      // sorted insert: walk while stored expiry <= new expiry
      S_A_HEAD: begin
        if (head_rd >= TC_L) begin
          cur_d   = NIL_LINK;
          state_d = S_LINK1;
        end else begin
          cur_d  = head_rd;
          exp_re = 1'b1; exp_ra = head_rd[TIX_W-1:0];
          nxt_re = 1'b1; nxt_ra = head_rd[TIX_W-1:0];
          state_d = S_A_CMP;
        end
      end
      S_A_CMP: begin
        if (exp_rd <= cmd_q.expires) begin
          prev_d  = cur_q;
          guard_d = g_next;
          cur_d   = (nxt_rd >= TC_L) ? NIL_LINK : nxt_rd;
          if (nxt_rd >= TC_L || g_next >= TC_L) begin
            state_d = S_LINK1;
          end else begin
            exp_re = 1'b1; exp_ra = nxt_rd[TIX_W-1:0];
            nxt_re = 1'b1; nxt_ra = nxt_rd[TIX_W-1:0];
          end
        end else begin
          state_d = S_LINK1;
        end
      end
      S_LINK1: begin
        exp_we = 1'b1; exp_wa = cmd_q.timer_id[TIX_W-1:0];
        nxt_we = 1'b1; nxt_wa = cmd_q.timer_id[TIX_W-1:0]; nxt_wd = cur_q;
        prv_we = 1'b1; prv_wa = cmd_q.timer_id[TIX_W-1:0]; prv_wd = prev_q;
        pend_d[cmd_q.timer_id[TIX_W-1:0]] = 1'b1;
        if (prev_q == NIL_LINK) begin
          head_we = 1'b1;
          head_wd = LINK_W'(cmd_q.timer_id);
          hv_d[slot_q] = 1'b1;
        end
        state_d = S_LINK2;
      end
      S_LINK2: begin
        if (prev_q != NIL_LINK) begin
          nxt_we = 1'b1; nxt_wa = prev_q[TIX_W-1:0]; nxt_wd = LINK_W'(cmd_q.timer_id);
        end
        if (cur_q != NIL_LINK) begin
          prv_we = 1'b1; prv_wa = cur_q[TIX_W-1:0]; prv_wd = LINK_W'(cmd_q.timer_id);
        end
        res_d   = '{KIND_ARMED, cmd_q.timer_id, 1'b0, 1'b1};
        state_d = S_EMIT;
      end
      S_UNLINK: begin
        if (prv_rd == NIL_LINK) begin
          head_we = 1'b1; head_wa = slot_of(exp_rd); head_wd = nxt_rd;
          hv_d[slot_of(exp_rd)] = 1'b1;
        end else if (prv_rd < TC_L) begin
          nxt_we = 1'b1; nxt_wa = prv_rd[TIX_W-1:0]; nxt_wd = nxt_rd;
        end
        if (nxt_rd < TC_L) begin
          prv_we = 1'b1; prv_wa = nxt_rd[TIX_W-1:0]; prv_wd = prv_rd;
        end
        pend_d[cmd_q.timer_id[TIX_W-1:0]] = 1'b0;
        res_d   = '{KIND_CANCEL, cmd_q.timer_id, 1'b1, 1'b1};
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          out_d    = res_q;
          state_d  = S_IDLE;
        end
      end
      // tick walk, newest slot first
      S_T_SLOT: begin
        if (remain_q == '0) begin
          state_d = S_T_END;
        end else begin
          slot_d  = slot_of(t_q);
          head_re = 1'b1;
          head_ra = slot_of(t_q);
          state_d = S_T_HEAD;
        end
      end
      S_T_HEAD: begin
        if (head_rd >= TC_L) begin
          t_d      = t_q - SLOT_STEP;
          remain_d = remain_q - CNT_W'(1);
          state_d  = S_T_SLOT;
        end else begin
          cur_d  = head_rd;
          exp_re = 1'b1; exp_ra = head_rd[TIX_W-1:0];
          nxt_re = 1'b1; nxt_ra = head_rd[TIX_W-1:0];
          state_d = S_T_EXP;
        end
      end
      S_T_EXP: begin
        if (exp_rd > cmd_q.now) begin
          t_d      = t_q - SLOT_STEP;
          remain_d = remain_q - CNT_W'(1);
          state_d  = S_T_SLOT;
        end else if (!hold_valid_q || out_free) begin
          // the held id is not the last one, so it goes out now
          if (hold_valid_q) begin
            out_load = 1'b1;
            out_d    = '{KIND_EXPIRED, hold_id_q, 1'b0, 1'b0};
          end
          head_we = 1'b1; head_wd = nxt_rd;
          hv_d[slot_q] = 1'b1;
          pend_d[cur_q[TIX_W-1:0]] = 1'b0;
          hold_valid_d = 1'b1;
          hold_id_d    = ID_W'(cur_q);
          if (nxt_rd < TC_L) begin
            prv_we = 1'b1; prv_wa = nxt_rd[TIX_W-1:0]; prv_wd = NIL_LINK;
            cur_d  = nxt_rd;
            exp_re = 1'b1; exp_ra = nxt_rd[TIX_W-1:0];
            nxt_re = 1'b1; nxt_ra = nxt_rd[TIX_W-1:0];
          end else begin
            t_d      = t_q - SLOT_STEP;
            remain_d = remain_q - CNT_W'(1);
            state_d  = S_T_SLOT;
          end
        end
      end
      S_T_END: begin
        if (out_free) begin
          out_load = 1'b1;
          if (hold_valid_q) begin
            out_d = '{KIND_EXPIRED, hold_id_q, 1'b0, 1'b1};
          end else begin
            out_d = '{KIND_NONE, 6'd0, 1'b0, 1'b1};
          end
          last_start_d = start_q;
          hold_valid_d = 1'b0;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      pend_q       <= '0;
      hv_q         <= '0;
      last_start_q <= '0;
      hold_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      pend_q       <= pend_d;
      hv_q         <= hv_d;
      last_start_q <= last_start_d;
      hold_valid_q <= hold_valid_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;  cur_q <= cur_d;  prev_q <= prev_d;  guard_q <= guard_d;
    slot_q <= slot_d;  t_q <= t_d;  start_q <= start_d;  remain_q <= remain_d;
    hold_id_q <= hold_id_d;  res_q <= res_d;
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // the output register is only refilled once its beat has gone
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> out_free) else $error("output beat overwritten");
  // nothing held over between commands
  a_hold_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !hold_valid_q) else $error("stale held expiry");
  // a popped timer is a real pool entry
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_T_EXP |-> cur_q < TC_L) else $error("walk on empty link");
  // an armed timer is marked pending before its result goes out
  a_armed_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_LINK2 |-> pend_q[cmd_q.timer_id[TIX_W-1:0]])
    else $error("armed timer not pending");
endmodule

FILE: src/slotted_timer_wheel_top.sv
// ----------------------------------------------------------------------------
// slotted_timer_wheel_top
// hashed timing wheel over a fixed pool of timers with sorted slots
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid_i / in_stall_o / in_item_i) carries commands:
//   arm a timer, cancel a timer, or tick at the current time. the unused
//   code is dropped with no result.
//   output channel (out_valid_o / out_stall_i / out_item_o) returns one beat
//   per arm or cancel, and for a tick one beat per expired timer (oldest
//   slot last, sorted within a slot) or a single "none" beat. the final beat
//   of each command carries last.
// sequencing:
//   a two-entry command queue decouples intake from the sequencer, which
//   handles one command at a time. an arm walks the timers passed in the
//   sorted slot list, a cancel reads the links and unlinks. a tick walks
//   slot by slot and pops each expired timer; the walk covers at most
//   SLOT_COUNT slots. link memories with registered reads set the pace.
// reset:
//   all timers idle, all slots empty (per-slot valid bits), last slot start
//   zero. no clearing pass is needed.
// backpressure:
//   while out_stall_i is high the result register holds and the sequencer
//   waits; once the queue fills, in_stall_o rises.
// ----------------------------------------------------------------------------
module slotted_timer_wheel_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  stw_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output stw_pkg::out_item_t out_item_o
);
  import stw_pkg::*;

  // queue between intake and sequencer
  logic     q_valid;
  logic     q_pop;
  in_item_t q_item;

  stw_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .in_item_i,
    .q_valid_o (q_valid),
    .q_pop_i   (q_pop),
    .q_item_o  (q_item)
  );

  stw_back u_back (
    .clk_i,
    .rst_ni,
    .q_valid_i  (q_valid),
    .q_pop_o    (q_pop),
    .q_item_i   (q_item),
    .out_valid_o,
    .out_stall_i,
    .out_item_o
  );
endmodule
